// ===== rtl/mff_pkg.sv =====
package mff_pkg;

   localparam int MAX_ITEMS_DEFAULT = 256;
   localparam int KEY_BITS_DEFAULT  = 64;
   localparam int VOTE_KEY_W        = 64;
   localparam int WINNER_COUNT_W    = 9;
   localparam int COUNT_SAT         = 511;

   typedef enum logic {
      KIND_RAW    = 1'b0,
      KIND_DOUBLE = 1'b1
   } key_kind_type;

   typedef struct packed {
      logic [VOTE_KEY_W-1:0] vote_key;
      logic                  last_vote;
   } req_payload_type;

   typedef struct packed {
      logic [VOTE_KEY_W-1:0]     winner_key;
      logic [WINNER_COUNT_W-1:0] winner_count;
      logic                      overflow;
   } rsp_payload_type;

   // Control flags that travel with a vote down the row of cells.
   typedef struct packed {
      logic         valid;
      logic         live;
      logic         found;
      logic         last;
      logic         drop;
      key_kind_type mode;
   } token_ctl_type;

   function automatic logic is_nan(input logic [VOTE_KEY_W-1:0] k);
      return (k[62:52] == 11'h7FF) && (k[51:0] != 52'd0);
   endfunction

   function automatic logic keys_match(input logic [VOTE_KEY_W-1:0] a,
                                       input logic [VOTE_KEY_W-1:0] b,
                                       input key_kind_type          kind);
      logic result;
      if (kind == KIND_RAW) begin
         result = (a == b);
      end else if (is_nan(a) || is_nan(b)) begin
         result = 1'b0;
      end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
         result = 1'b1;
      end else begin
         result = (a == b);
      end
      return result;
   endfunction

endpackage

// ===== rtl/mode_finder_first_tie.sv =====
// Path: a vote accepted into the head register walks the MAX_ITEMS key cells to the tracker,
// which registers the result of the transaction closing a set.
// Throughput: one vote per cycle; each vote walks the row of MAX_ITEMS key cells one cell
// a cycle, and the whole row holds while a finished result waits on rsp_ready.
// Reset: synchronous, active high; empties every cell, clears the leader and the
// key_kind register.
module mode_finder_first_tie #(
   parameter int MAX_ITEMS = mff_pkg::MAX_ITEMS_DEFAULT,
   parameter int KEY_BITS  = mff_pkg::KEY_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mff_pkg::req_payload_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mff_pkg::rsp_payload_type  rsp_data,
   input  logic                      csr_write_enable,
   input  logic                      csr_write_data
);
   import mff_pkg::*;

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W = $clog2(MAX_ITEMS);

   key_kind_type        key_kind_ff;
   logic [CNT_W-1:0]    items_ff, items_in;
   token_ctl_type       head_ctl_ff, head_ctl_in;
   logic [KEY_BITS-1:0] head_key_ff;
   logic                advance;
   logic                accept;
   logic                drop;
   logic [VOTE_KEY_W-1:0] masked_key;

   token_ctl_type       stage_ctl   [MAX_ITEMS+1];
   logic [KEY_BITS-1:0] stage_key   [MAX_ITEMS+1];
   logic [CNT_W-1:0]    stage_count [MAX_ITEMS+1];
   logic [IDX_W-1:0]    stage_index [MAX_ITEMS+1];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   always_comb begin
      masked_key = VOTE_KEY_W'(req_data.vote_key[KEY_BITS-1:0]);
      drop       = (items_ff >= CNT_W'(MAX_ITEMS));

      items_in = items_ff;
      if (accept) begin
         if (req_data.last_vote) begin
            items_in = '0;
         end else if (!drop) begin
            items_in = items_ff + CNT_W'(1);
         end
      end

      head_ctl_in       = '0;
      head_ctl_in.valid = accept;
      head_ctl_in.live  = accept && !drop &&
                          !((key_kind_ff == KIND_DOUBLE) && is_nan(masked_key));
      head_ctl_in.last  = accept && req_data.last_vote;
      head_ctl_in.drop  = accept && drop;
      head_ctl_in.mode  = key_kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_kind_ff <= KIND_RAW;
      end else if (csr_write_enable) begin
         key_kind_ff <= key_kind_type'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff    <= '0;
         head_ctl_ff <= '0;
      end else if (advance) begin
         items_ff    <= items_in;
         head_ctl_ff <= head_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         head_key_ff <= req_data.vote_key[KEY_BITS-1:0];
      end
   end

   assign stage_ctl[0]   = head_ctl_ff;
   assign stage_key[0]   = head_key_ff;
   assign stage_count[0] = '0;
   assign stage_index[0] = '0;

   for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
      mff_cell #(
         .MAX_ITEMS  (MAX_ITEMS),
         .KEY_BITS   (KEY_BITS),
         .CELL_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_ctl    (stage_ctl[g]),
         .in_key    (stage_key[g]),
         .in_count  (stage_count[g]),
         .in_index  (stage_index[g]),
         .out_ctl   (stage_ctl[g+1]),
         .out_key   (stage_key[g+1]),
         .out_count (stage_count[g+1]),
         .out_index (stage_index[g+1])
      );
   end

   mff_tracker #(
      .MAX_ITEMS (MAX_ITEMS),
      .KEY_BITS  (KEY_BITS)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_ctl    (stage_ctl[MAX_ITEMS]),
      .in_key    (stage_key[MAX_ITEMS]),
      .in_count  (stage_count[MAX_ITEMS]),
      .in_index  (stage_index[MAX_ITEMS]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/mff_cell.sv =====
module mff_cell #(
   parameter int MAX_ITEMS  = mff_pkg::MAX_ITEMS_DEFAULT,
   parameter int KEY_BITS   = mff_pkg::KEY_BITS_DEFAULT,
   parameter int CELL_INDEX = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  mff_pkg::token_ctl_type             in_ctl,
   input  logic [KEY_BITS-1:0]                in_key,
   input  logic [$clog2(MAX_ITEMS+1)-1:0]     in_count,
   input  logic [$clog2(MAX_ITEMS)-1:0]       in_index,
   output mff_pkg::token_ctl_type             out_ctl,
   output logic [KEY_BITS-1:0]                out_key,
   output logic [$clog2(MAX_ITEMS+1)-1:0]     out_count,
   output logic [$clog2(MAX_ITEMS)-1:0]       out_index
);
   import mff_pkg::*;

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W = $clog2(MAX_ITEMS);

   logic                 valid_ff, valid_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   token_ctl_type        out_ctl_ff, out_ctl_in;
   logic [KEY_BITS-1:0]  out_key_ff, out_key_in;
   logic [CNT_W-1:0]     out_count_ff, out_count_in;
   logic [IDX_W-1:0]     out_index_ff, out_index_in;
   logic                 hit;
   logic                 claim;

   always_comb begin
      hit = valid_ff && in_ctl.live && !in_ctl.found &&
            keys_match(VOTE_KEY_W'(key_ff), VOTE_KEY_W'(in_key), in_ctl.mode);
      claim = !valid_ff && in_ctl.live && !in_ctl.found;

      valid_in = valid_ff;
      key_in   = key_ff;
      count_in = count_ff;
      if (hit) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (claim) begin
         valid_in = 1'b1;
         key_in   = in_key;
         count_in = CNT_W'(1);
      end
      // The closing vote of a set empties the cell behind it.
      if (in_ctl.valid && in_ctl.last) begin
         valid_in = 1'b0;
      end

      out_ctl_in       = in_ctl;
      out_ctl_in.found = in_ctl.found | hit | claim;
      out_key_in       = hit ? key_ff : in_key;
      out_count_in     = (hit || claim) ? count_in : in_count;
      out_index_in     = (hit || claim) ? IDX_W'(CELL_INDEX) : in_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         out_ctl_ff <= '0;
      end else if (enable) begin
         valid_ff   <= valid_in;
         out_ctl_ff <= out_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         key_ff       <= key_in;
         count_ff     <= count_in;
         out_key_ff   <= out_key_in;
         out_count_ff <= out_count_in;
         out_index_ff <= out_index_in;
      end
   end

   assign out_ctl   = out_ctl_ff;
   assign out_key   = out_key_ff;
   assign out_count = out_count_ff;
   assign out_index = out_index_ff;

endmodule

// ===== rtl/mff_tracker.sv =====
module mff_tracker #(
   parameter int MAX_ITEMS = mff_pkg::MAX_ITEMS_DEFAULT,
   parameter int KEY_BITS  = mff_pkg::KEY_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               enable,
   input  mff_pkg::token_ctl_type             in_ctl,
   input  logic [KEY_BITS-1:0]                in_key,
   input  logic [$clog2(MAX_ITEMS+1)-1:0]     in_count,
   input  logic [$clog2(MAX_ITEMS)-1:0]       in_index,
   output logic                               rsp_valid,
   output mff_pkg::rsp_payload_type           rsp_data
);
   import mff_pkg::*;

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W = $clog2(MAX_ITEMS);

   logic [CNT_W-1:0]    lead_count_ff, lead_count_in;
   logic [IDX_W-1:0]    lead_index_ff, lead_index_in;
   logic [KEY_BITS-1:0] lead_key_ff, lead_key_in;
   logic                overflow_ff, overflow_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_payload_type     rsp_data_ff, rsp_data_in;
   logic                take;
   logic                close;

   always_comb begin
      take = in_ctl.found &&
             ((in_count > lead_count_ff) ||
              ((in_count == lead_count_ff) && (in_index < lead_index_ff)));
      close = in_ctl.valid && in_ctl.last;

      lead_count_in = take ? in_count : lead_count_ff;
      lead_index_in = take ? in_index : lead_index_ff;
      lead_key_in   = take ? in_key : lead_key_ff;
      overflow_in   = overflow_ff | (in_ctl.valid & in_ctl.drop);

      rsp_valid_in = close;
      rsp_data_in  = rsp_data_ff;
      if (close) begin
         rsp_data_in.winner_key   = (lead_count_in != '0) ?
                                    VOTE_KEY_W'(lead_key_in) : '0;
         rsp_data_in.winner_count = (32'(lead_count_in) > 32'(COUNT_SAT)) ?
                                    WINNER_COUNT_W'(COUNT_SAT) :
                                    WINNER_COUNT_W'(lead_count_in);
         rsp_data_in.overflow     = overflow_in;
         lead_count_in            = '0;
         lead_index_in            = '0;
         overflow_in              = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_count_ff <= '0;
         lead_index_ff <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (enable) begin
         lead_count_ff <= lead_count_in;
         lead_index_ff <= lead_index_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lead_key_ff <= lead_key_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/mff_checker.sv =====
module mff_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input mff_pkg::rsp_payload_type  rsp_data
);
   import mff_pkg::*;

   // A result that is not taken stays put.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("result transaction changed while stalled");

   // While a result waits, the row of cells holds and no vote is taken.
   property p_stall_blocks_input;
      @(posedge clock) (rsp_valid && !rsp_ready) |-> !req_ready;
   endproperty
   a_stall_blocks_input: assert property (p_stall_blocks_input)
      else $error("vote transaction taken while a result was stalled");

   // A set with no counted vote reports key zero.
   property p_empty_winner;
      @(posedge clock) disable iff (reset)
         (rsp_valid && (rsp_data.winner_count == '0)) |-> (rsp_data.winner_key == '0);
   endproperty
   a_empty_winner: assert property (p_empty_winner)
      else $error("nonzero winner key with zero count");

   // Nothing is reported right after reset.
   property p_reset_quiet;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_quiet: assert property (p_reset_quiet)
      else $error("result transaction right after reset");

endmodule

bind mode_finder_first_tie mff_checker u_mff_checker (.*);

// ===== verif/mode_finder_first_tie_tb.sv =====
module mode_finder_first_tie_tb;
   import mff_pkg::*;

   localparam int MAX_VOTES   = MAX_ITEMS_DEFAULT;
   localparam int DRAIN_WAIT  = MAX_VOTES + 12;
   localparam int QUIET_LIMIT = 10000;
   localparam int LONG_HOLD   = 1200;

   localparam logic [63:0] POS_ZERO = 64'h0000_0000_0000_0000;
   localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ONE_DBL  = 64'h3FF0_0000_0000_0000;
   localparam logic [63:0] POS_INF  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] NAN_A    = 64'h7FF8_0000_0000_0001;
   localparam logic [63:0] NAN_B    = 64'hFFF0_0000_0000_0100;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;
   logic            csr_write_enable;
   logic            csr_write_data;

   req_payload_type ballot_q[$];
   rsp_payload_type winner_q[$];

   logic [63:0]  tally_keys [MAX_VOTES];
   int           tally_counts [MAX_VOTES];
   int           tally_entries = 0;
   int           tally_items = 0;
   int           lead_slot = 0;
   int           lead_count = 0;
   bit           set_dropped = 1'b0;
   key_kind_type kind_now = KIND_RAW;

   bit vote_took = 1'b0;
   bit reply_took = 1'b0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int send_gap = 0;
   int reply_wait = 0;
   int stall_left = 0;
   bit send_gappy = 1'b1;
   bit reply_gappy = 1'b1;
   bit send_rush = 1'b0;
   bit stall_request = 1'b0;
   bit stall_done = 1'b0;

   mode_finder_first_tie dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit nan_key(input logic [63:0] k);
      return (k[62:52] == 11'h7FF) && (k[51:0] != 52'd0);
   endfunction

   function automatic bit same_key(input logic [63:0] a, input logic [63:0] b);
      if (kind_now == KIND_RAW) return a == b;
      if (nan_key(a) || nan_key(b)) return 1'b0;
      if (a[62:0] == 63'd0 && b[62:0] == 63'd0) return 1'b1;
      return a == b;
   endfunction

   function automatic void clear_tally();
      tally_entries = 0;
      tally_items = 0;
      lead_slot = 0;
      lead_count = 0;
      set_dropped = 1'b0;
   endfunction

   function automatic void count_ballot(input req_payload_type v);
      int              i;
      rsp_payload_type w;
      if (tally_items >= MAX_VOTES) begin
         set_dropped = 1'b1;
      end else begin
         tally_items++;
         if (!(kind_now == KIND_DOUBLE && nan_key(v.vote_key))) begin
            i = 0;
            while (i < tally_entries && !same_key(tally_keys[i], v.vote_key)) i++;
            if (i == tally_entries) begin
               tally_keys[i] = v.vote_key;
               tally_counts[i] = 0;
               tally_entries++;
            end
            tally_counts[i]++;
            if (tally_counts[i] > lead_count ||
                (tally_counts[i] == lead_count && i < lead_slot)) begin
               lead_count = tally_counts[i];
               lead_slot = i;
            end
         end
      end
      if (v.last_vote) begin
         w.winner_key = (lead_count != 0) ? tally_keys[lead_slot] : 64'd0;
         w.winner_count = WINNER_COUNT_W'((lead_count > COUNT_SAT) ? COUNT_SAT : lead_count);
         w.overflow = set_dropped;
         winner_q.push_back(w);
         clear_tally();
      end
   endfunction

   function automatic logic [63:0] odd_key();
      logic [63:0] k;
      k = {$urandom, $urandom};
      case ($urandom_range(0, 6))
         0: k = POS_ZERO;
         1: k = NEG_ZERO;
         2: begin
            k[62:52] = 11'h7FF;
            if (k[51:0] == 52'd0) k[0] = 1'b1;
         end
         3: k = {k[63], POS_INF[62:0]};
         4: k = '1;
         5: k = {k[63], ONE_DBL[62:0]};
         default: k[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
      endcase
      return k;
   endfunction

   function automatic logic [63:0] pick_key();
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         1: return 64'($urandom_range(0, 3));
         default: return odd_key();
      endcase
   endfunction

   task automatic cast_ballot(input logic [63:0] k, input bit last);
      req_payload_type v;
      v.vote_key = k;
      v.last_vote = last;
      ballot_q.push_back(v);
   endtask

   task automatic queue_set(input int len, input int pool_n, input bit closed);
      logic [63:0] pool [8];
      logic [63:0] k;
      int          r;
      for (int p = 0; p < 8; p++) pool[p] = pick_key();
      for (int j = 0; j < len; j++) begin
         r = $urandom_range(0, 19);
         if (r == 0) k = {$urandom, $urandom};
         else if (r == 1) k = odd_key();
         else k = pool[$urandom_range(0, pool_n - 1)];
         cast_ballot(k, closed && j == len - 1);
      end
   endtask

   task automatic run_sets(input int quota);
      int n;
      int len;
      n = 0;
      while (n < quota) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
         queue_set(len, $urandom_range(1, 6), 1'b1);
         n += len;
      end
   endtask

   task automatic wait_idle();
      while (ballot_q.size() != 0 || req_valid || winner_q.size() != 0) @(posedge clock);
   endtask

   // Votes of an unfinished set may still be walking the row, so let it drain first.
   task automatic switch_kind(input key_kind_type kind);
      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= kind;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || vote_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (ballot_q.size() != 0) begin
            req_data <= ballot_q.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 49) == 0) send_gappy = !send_gappy;
            send_gap = (send_gappy && !send_rush) ? $urandom_range(0, 12) : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_request && !stall_done) begin
            stall_left = LONG_HOLD;
            stall_done = 1'b1;
         end
         if (reply_took) begin
            if ($urandom_range(0, 39) == 0) reply_gappy = !reply_gappy;
            reply_wait = reply_gappy ? $urandom_range(0, 12) : 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (reply_wait > 0) begin
            reply_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      vote_took = 1'b0;
      reply_took = 1'b0;
      if (reset) begin
         kind_now = KIND_RAW;
         clear_tally();
      end else begin
         if (csr_write_enable) kind_now = key_kind_type'(csr_write_data);
         if (req_valid && req_ready) begin
            vote_took = 1'b1;
            count_ballot(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            reply_took = 1'b1;
            if (winner_q.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected transaction: key %h count %0d overflow %0b",
                           rsp_data.winner_key, rsp_data.winner_count, rsp_data.overflow);
               mismatches++;
            end else begin
               want = winner_q.pop_front();
               if (rsp_data.winner_key !== want.winner_key ||
                   rsp_data.winner_count !== want.winner_count ||
                   rsp_data.overflow !== want.overflow) begin
                  if (mismatches < 10)
                     $display("mismatch: expected key %h count %0d overflow %0b, got key %h count %0d overflow %0b",
                              want.winner_key, want.winner_count, want.overflow,
                              rsp_data.winner_key, rsp_data.winner_count, rsp_data.overflow);
                  mismatches++;
               end
            end
         end
         if (vote_took || reply_took) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      cast_ballot(POS_ZERO, 1'b1);
      cast_ballot('1, 1'b1);
      cast_ballot(64'd5, 1'b0);
      cast_ballot(64'd9, 1'b0);
      cast_ballot(64'd9, 1'b0);
      cast_ballot(64'd5, 1'b0);
      cast_ballot(64'd3, 1'b1);
      cast_ballot(POS_ZERO, 1'b0);
      cast_ballot(NEG_ZERO, 1'b1);
      switch_kind(KIND_DOUBLE);
      cast_ballot(NEG_ZERO, 1'b0);
      cast_ballot(POS_ZERO, 1'b1);
      cast_ballot(NAN_A, 1'b0);
      cast_ballot(NAN_A, 1'b1);
      cast_ballot(NAN_B, 1'b0);
      cast_ballot(ONE_DBL, 1'b0);
      cast_ballot(NAN_A, 1'b1);
      cast_ballot(POS_INF, 1'b0);
      cast_ballot(POS_INF, 1'b1);
      cast_ballot(ONE_DBL, 1'b0);
      cast_ballot(NAN_A, 1'b0);
      switch_kind(KIND_RAW);
      cast_ballot(NAN_A, 1'b0);
      cast_ballot(NAN_A, 1'b1);

      for (int ph = 0; ph < 6; ph++) begin
         switch_kind((ph % 2 == 0) ? KIND_DOUBLE : KIND_RAW);
         send_rush = (ph == 2);
         if (ph == 2) begin
            // Hold the result side while votes keep coming so the row backs up.
            stall_request = 1'b1;
            run_sets(120);
            queue_set(257 + $urandom_range(0, 8), $urandom_range(1, 4), 1'b1);
         end else begin
            run_sets(60);
         end
         if (ph == 3) begin
            k = pick_key();
            for (int j = 0; j < MAX_VOTES; j++) cast_ballot(k, j == MAX_VOTES - 1);
         end
         if (ph == 5) queue_set(257 + $urandom_range(0, 8), $urandom_range(1, 4), 1'b1);
         if (ph == 1 || ph == 4) queue_set($urandom_range(1, 8), $urandom_range(1, 3), 1'b0);
      end
      queue_set($urandom_range(1, 6), 2, 1'b1);

      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
